// ===== hdl/plist_pkg.sv =====
// Shared types and codes for the positional list block.
package plist_pkg;

    localparam int unsigned VAL_W   = 32;
    localparam int unsigned POS_W   = 8;
    localparam int unsigned COUNT_W = 8;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADPOS = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DISPATCH = 8'b0000_0010,
        S_FETCH    = 8'b0000_0100,
        S_GRAB     = 8'b0000_1000,
        S_MOVE_RD  = 8'b0001_0000,
        S_MOVE_WR  = 8'b0010_0000,
        S_PUT      = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic fetch;
        logic grab;
        logic move_wr;
        logic put;
        logic load;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_op     op;
        t_status status;
        logic    last;
        logic    pos_eq_len;
    } t_stat;

endpackage

// ===== hdl/plist_ctrl.sv =====
// Sequencing state machine for the positional list block.
module plist_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  plist_pkg::t_stat i_stat,
    output plist_pkg::t_cmd  o_cmd
);

    plist_pkg::t_state r_state, n_state;
    logic              r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= plist_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            plist_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = plist_pkg::S_DISPATCH;
                end
            end
            plist_pkg::S_DISPATCH: begin
                if (i_stat.status != plist_pkg::ST_OK) begin
                    n_state = plist_pkg::S_DONE;
                end else begin
                    case (i_stat.op)
                        plist_pkg::OP_APPEND: n_state = plist_pkg::S_PUT;
                        plist_pkg::OP_INSERT: n_state = plist_pkg::S_MOVE_RD;
                        default:              n_state = plist_pkg::S_FETCH;
                    endcase
                end
            end
            plist_pkg::S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = plist_pkg::S_GRAB;
            end
            plist_pkg::S_GRAB: begin
                o_cmd.grab = 1'b1;
                if (i_stat.op == plist_pkg::OP_DELETE && !i_stat.pos_eq_len) begin
                    n_state = plist_pkg::S_MOVE_RD;
                end else begin
                    n_state = plist_pkg::S_DONE;
                end
            end
            plist_pkg::S_MOVE_RD: begin
                n_state = plist_pkg::S_MOVE_WR;
            end
            plist_pkg::S_MOVE_WR: begin
                o_cmd.move_wr = 1'b1;
                if (!i_stat.last) begin
                    n_state = plist_pkg::S_MOVE_RD;
                end else if (i_stat.op == plist_pkg::OP_INSERT) begin
                    n_state = plist_pkg::S_PUT;
                end else begin
                    n_state = plist_pkg::S_DONE;
                end
            end
            plist_pkg::S_PUT: begin
                o_cmd.put = 1'b1;
                n_state   = plist_pkg::S_DONE;
            end
            plist_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = plist_pkg::S_IDLE;
                end
            end
            default: n_state = plist_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_in_ready  = (r_state == plist_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== hdl/plist_dp.sv =====
// Datapath of the positional list block: entry store, length, word registers.
module plist_dp #(
    parameter int unsigned CAPACITY = 128
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  plist_pkg::t_cmd                        i_cmd,
    output plist_pkg::t_stat                       o_stat,
    input  logic [1:0]                             i_op,
    input  logic [plist_pkg::POS_W-1:0]            i_pos,
    input  logic signed [plist_pkg::VAL_W-1:0]     i_value,
    output logic                                   o_ok,
    output logic [1:0]                             o_status,
    output logic signed [plist_pkg::VAL_W-1:0]     o_value_out,
    output logic [plist_pkg::COUNT_W-1:0]          o_count
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned LW = $clog2(CAPACITY + 1);
    localparam int unsigned PW = (LW > plist_pkg::POS_W) ? LW : plist_pkg::POS_W;

    logic [plist_pkg::VAL_W-1:0] mem [CAPACITY];
    logic [plist_pkg::VAL_W-1:0] r_rdata;

    logic [LW-1:0]               r_len, n_len;
    plist_pkg::t_op              r_op;
    plist_pkg::t_status          r_status, n_status;
    logic [PW-1:0]               r_pos;
    logic [plist_pkg::VAL_W-1:0] r_value;
    logic [plist_pkg::VAL_W-1:0] r_got;
    logic [AW-1:0]               r_idx, n_idx;

    logic [plist_pkg::VAL_W-1:0] r_value_out;
    logic                        r_ok;
    logic [1:0]                  r_status_out;
    logic [plist_pkg::COUNT_W-1:0] r_count;

    logic [PW-1:0]               pos_w, len_w;
    logic                        full, empty, badpos;
    plist_pkg::t_op              in_op;
    logic [AW-1:0]               pos_m1, len_m1, raddr, waddr;
    logic [plist_pkg::VAL_W-1:0] wdata;
    logic                        we, fetched_op;

    // admission checks against the current length
    assign in_op  = plist_pkg::t_op'(i_op);
    assign pos_w  = PW'(i_pos);
    assign len_w  = PW'(r_len);
    assign full   = (r_len == LW'(CAPACITY));
    assign empty  = (r_len == '0);
    assign badpos = (pos_w == '0) || (pos_w > len_w);

    always_comb begin
        case (in_op)
            plist_pkg::OP_APPEND:
                n_status = full ? plist_pkg::ST_FULL : plist_pkg::ST_OK;
            plist_pkg::OP_INSERT:
                n_status = full   ? plist_pkg::ST_FULL :
                           badpos ? plist_pkg::ST_BADPOS : plist_pkg::ST_OK;
            default:
                n_status = empty  ? plist_pkg::ST_EMPTY :
                           badpos ? plist_pkg::ST_BADPOS : plist_pkg::ST_OK;
        endcase
    end

    assign pos_m1 = AW'(r_pos - PW'(1));
    assign len_m1 = AW'(len_w - PW'(1));

    // insert walks down from the tail, delete walks up from the gap
    always_comb begin
        if (i_cmd.accept) begin
            n_idx = (in_op == plist_pkg::OP_INSERT) ? AW'(len_w - PW'(1)) : AW'(pos_w);
        end else if (i_cmd.move_wr) begin
            n_idx = (r_op == plist_pkg::OP_INSERT) ? r_idx - AW'(1) : r_idx + AW'(1);
        end else begin
            n_idx = r_idx;
        end
    end

    assign raddr = i_cmd.fetch ? pos_m1 : r_idx;
    assign we    = i_cmd.move_wr | i_cmd.put;

    always_comb begin
        if (i_cmd.move_wr) begin
            waddr = (r_op == plist_pkg::OP_INSERT) ? r_idx + AW'(1) : r_idx - AW'(1);
            wdata = r_rdata;
        end else begin
            waddr = (r_op == plist_pkg::OP_APPEND) ? AW'(r_len) : pos_m1;
            wdata = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[raddr];
    end

    always_comb begin
        n_len = r_len;
        if (r_status == plist_pkg::ST_OK) begin
            case (r_op)
                plist_pkg::OP_APPEND,
                plist_pkg::OP_INSERT: n_len = r_len + LW'(1);
                plist_pkg::OP_DELETE: n_len = r_len - LW'(1);
                default:              n_len = r_len;
            endcase
        end
    end

    assign fetched_op = (r_op == plist_pkg::OP_DELETE) || (r_op == plist_pkg::OP_READ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_cmd.load) begin
            r_len <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.accept) begin
            r_op     <= in_op;
            r_status <= n_status;
            r_pos    <= pos_w;
            r_value  <= i_value;
        end
        if (i_cmd.grab) begin
            r_got <= r_rdata;
        end
        if (i_cmd.load) begin
            r_ok         <= (r_status == plist_pkg::ST_OK);
            r_status_out <= r_status;
            r_value_out  <= (r_status == plist_pkg::ST_OK && fetched_op) ? r_got : '0;
            r_count      <= plist_pkg::COUNT_W'(n_len);
        end
    end

    always_comb begin
        o_stat.op         = r_op;
        o_stat.status     = r_status;
        o_stat.last       = (r_op == plist_pkg::OP_INSERT) ? (r_idx == pos_m1)
                                                           : (r_idx == len_m1);
        o_stat.pos_eq_len = (r_pos == len_w);
    end

    assign o_ok        = r_ok;
    assign o_status    = r_status_out;
    assign o_value_out = r_value_out;
    assign o_count     = r_count;

endmodule

// ===== hdl/positional_list_insert_delete.sv =====
// Top level of the positional list block: ordered list with positional edits.
//
// Input channel (i_in_valid / o_in_ready) carries one command word: i_op,
// i_pos (1-based), i_value. Output channel (o_out_valid / i_out_ready)
// returns one result word per command: o_ok, o_status, o_value_out, o_count.
// One command is in flight at a time; o_in_ready is high only when idle.
// Steps from acceptance to result register load: every command is dispatched;
//   append writes the entry; read fetches it; delete fetches it and moves each
//   later entry down; insert moves the entries from pos to the tail up and then
//   writes the new entry; a rejected command goes straight to the result.
// The next command is accepted in the cycle after the load at the earliest.
// The length sets the cost of insert and delete: every moved entry takes a read
// and a write on the entry memory.
// The result sits in an output register; if the receiver stalls, the block
// holds the finished result and waits, then accepts the next command once the
// word has moved into the output register.
// Reset (i_rst_n low, synchronous) empties the list and drops any pending
// result; entry contents are not cleared and need no clearing pass.
module positional_list_insert_delete #(
    parameter int unsigned CAPACITY = 128
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [1:0]                         i_op,
    input  logic [plist_pkg::POS_W-1:0]        i_pos,
    input  logic signed [plist_pkg::VAL_W-1:0] i_value,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_ok,
    output logic [1:0]                         o_status,
    output logic signed [plist_pkg::VAL_W-1:0] o_value_out,
    output logic [plist_pkg::COUNT_W-1:0]      o_count
);

    plist_pkg::t_cmd  cmd;
    plist_pkg::t_stat stat;

    plist_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    plist_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_op        (i_op),
        .i_pos       (i_pos),
        .i_value     (i_value),
        .o_ok        (o_ok),
        .o_status    (o_status),
        .o_value_out (o_value_out),
        .o_count     (o_count)
    );

endmodule

// ===== tb/positional_list_insert_delete_tb.sv =====
// Self-checking testbench for the positional list block: directed, fill and random commands.
module positional_list_insert_delete_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CAPACITY    = 128;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam longint      CYCLE_LIMIT = 2_000_000;
    localparam int unsigned MAX_SHOWN   = 10;

    typedef struct packed {
        logic                               ok;
        plist_pkg::t_status                 status;
        logic signed [plist_pkg::VAL_W-1:0] value_out;
        logic [plist_pkg::COUNT_W-1:0]      count;
    } t_result;

    logic                               i_clk       = 1'b0;
    logic                               i_rst_n     = 1'b0;
    logic                               in_valid    = 1'b0;
    logic [1:0]                         in_op       = plist_pkg::OP_APPEND;
    logic [plist_pkg::POS_W-1:0]        in_pos      = '0;
    logic signed [plist_pkg::VAL_W-1:0] in_value    = '0;
    logic                               out_ready   = 1'b0;
    logic                               o_in_ready;
    logic                               o_out_valid;
    logic                               o_ok;
    logic [1:0]                         o_status;
    logic signed [plist_pkg::VAL_W-1:0] o_value_out;
    logic [plist_pkg::COUNT_W-1:0]      o_count;

    // shadow of the list
    logic signed [plist_pkg::VAL_W-1:0] shadow_entries [CAPACITY];
    int unsigned                        shadow_len = 0;
    t_result                            pending_results [$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_asked    = 0;
    int unsigned hold_served   = 0;
    int unsigned hold_count    = 0;
    int unsigned mismatches    = 0;
    longint      cycles        = 0;

    positional_list_insert_delete #(.CAPACITY(CAPACITY)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (in_op),
        .i_pos       (in_pos),
        .i_value     (in_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_ok        (o_ok),
        .o_status    (o_status),
        .o_value_out (o_value_out),
        .o_count     (o_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (hold_count != 0) begin
            hold_count <= hold_count - 1;
        end else if (hold_served != hold_asked) begin
            hold_served <= hold_asked;
            hold_count  <= HOLD_CYCLES;
        end
    end

    always @(posedge i_clk) begin
        out_ready <= (hold_count == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected result word: ok=%0d status=%0d value=%0d count=%0d",
                             o_ok, o_status, o_value_out, o_count);
            end else begin
                want = pending_results.pop_front();
                if (o_ok !== want.ok || o_status !== want.status ||
                    o_value_out !== want.value_out || o_count !== want.count) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN) begin
                        $write("result mismatch: expected ok=%0d status=%0d value=%0d count=%0d",
                               want.ok, want.status, want.value_out, want.count);
                        $display(", got ok=%0d status=%0d value=%0d count=%0d",
                                 o_ok, o_status, o_value_out, o_count);
                    end
                end
            end
        end
    end

    function automatic t_result predict_list_op(plist_pkg::t_op op,
                                                logic [plist_pkg::POS_W-1:0] pos,
                                                logic signed [plist_pkg::VAL_W-1:0] val);
        t_result     r;
        int unsigned i;
        r.ok        = 1'b0;
        r.status    = plist_pkg::ST_OK;
        r.value_out = '0;
        case (op)
            plist_pkg::OP_APPEND: begin
                if (shadow_len >= CAPACITY) begin
                    r.status = plist_pkg::ST_FULL;
                end else begin
                    shadow_entries[shadow_len] = val;
                    shadow_len++;
                end
            end
            plist_pkg::OP_INSERT: begin
                if (shadow_len >= CAPACITY) begin
                    r.status = plist_pkg::ST_FULL;
                end else if (pos < 1 || pos > shadow_len) begin
                    r.status = plist_pkg::ST_BADPOS;
                end else begin
                    for (i = shadow_len; i >= pos; i--)
                        shadow_entries[i] = shadow_entries[i-1];
                    shadow_entries[pos-1] = val;
                    shadow_len++;
                end
            end
            plist_pkg::OP_DELETE: begin
                if (shadow_len == 0) begin
                    r.status = plist_pkg::ST_EMPTY;
                end else if (pos < 1 || pos > shadow_len) begin
                    r.status = plist_pkg::ST_BADPOS;
                end else begin
                    r.value_out = shadow_entries[pos-1];
                    for (i = pos; i < shadow_len; i++)
                        shadow_entries[i-1] = shadow_entries[i];
                    shadow_len--;
                end
            end
            default: begin
                if (shadow_len == 0)
                    r.status = plist_pkg::ST_EMPTY;
                else if (pos < 1 || pos > shadow_len)
                    r.status = plist_pkg::ST_BADPOS;
                else
                    r.value_out = shadow_entries[pos-1];
            end
        endcase
        r.ok    = (r.status == plist_pkg::ST_OK);
        r.count = shadow_len[plist_pkg::COUNT_W-1:0];
        return r;
    endfunction

    task automatic send_word(plist_pkg::t_op op, logic [plist_pkg::POS_W-1:0] pos,
                             logic signed [plist_pkg::VAL_W-1:0] val);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_op    <= op;
        in_pos   <= pos;
        in_value <= val;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(predict_list_op(op, pos, val));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [plist_pkg::POS_W-1:0] legal_pos();
        return (shadow_len == 0) ? plist_pkg::POS_W'(1)
                                 : plist_pkg::POS_W'($urandom_range(1, shadow_len));
    endfunction

    task automatic test_directed();
        send_word(plist_pkg::OP_READ,   8'd1,   32'sd5);
        send_word(plist_pkg::OP_DELETE, 8'd0,   32'sd0);
        send_word(plist_pkg::OP_INSERT, 8'd1,   32'sd7);
        send_word(plist_pkg::OP_INSERT, 8'd0,   32'sd7);
        send_word(plist_pkg::OP_APPEND, 8'd0,   32'sh8000_0000);
        send_word(plist_pkg::OP_APPEND, 8'd0,   32'sh7fff_ffff);
        send_word(plist_pkg::OP_INSERT, 8'd0,   32'sd3);
        send_word(plist_pkg::OP_INSERT, 8'd3,   32'sd3);
        send_word(plist_pkg::OP_INSERT, 8'd1,   -32'sd1);
        send_word(plist_pkg::OP_INSERT, 8'd3,   32'sd0);
        send_word(plist_pkg::OP_INSERT, 8'd255, 32'sd9);
        send_word(plist_pkg::OP_READ,   8'd0,   32'sd0);
        send_word(plist_pkg::OP_READ,   8'd1,   32'sd0);
        send_word(plist_pkg::OP_READ,   8'd4,   32'sd0);
        send_word(plist_pkg::OP_READ,   8'd5,   32'sd0);
        send_word(plist_pkg::OP_READ,   8'd255, -32'sd1);
        send_word(plist_pkg::OP_DELETE, 8'd128, 32'sd0);
        send_word(plist_pkg::OP_DELETE, 8'd4,   32'sd0);
        send_word(plist_pkg::OP_DELETE, 8'd1,   32'sd0);
        send_word(plist_pkg::OP_APPEND, 8'd255, 32'sh5555_5555);
        send_word(plist_pkg::OP_READ,   8'd3,   32'shaaaa_aaaa);
        send_word(plist_pkg::OP_DELETE, 8'd2,   32'sd0);
        send_word(plist_pkg::OP_DELETE, 8'd1,   32'sd0);
        send_word(plist_pkg::OP_DELETE, 8'd1,   32'sd0);
        send_word(plist_pkg::OP_DELETE, 8'd1,   32'sd0);
    endtask

    task automatic test_fill_and_empty();
        while (shadow_len < CAPACITY) begin
            send_word(plist_pkg::OP_APPEND, plist_pkg::POS_W'($urandom), $urandom);
            if ($urandom_range(0, 15) == 0)
                send_word(plist_pkg::OP_READ, legal_pos(), $urandom);
        end
        send_word(plist_pkg::OP_APPEND, 8'd0,   $urandom);
        send_word(plist_pkg::OP_INSERT, 8'd1,   $urandom);
        send_word(plist_pkg::OP_INSERT, 8'd0,   $urandom);
        send_word(plist_pkg::OP_INSERT, 8'd200, $urandom);
        send_word(plist_pkg::OP_READ,   8'd128, $urandom);
        send_word(plist_pkg::OP_READ,   8'd129, $urandom);
        send_word(plist_pkg::OP_DELETE, 8'd128, $urandom);
        send_word(plist_pkg::OP_INSERT, 8'd127, $urandom);
        send_word(plist_pkg::OP_DELETE, 8'd129, $urandom);
        while (shadow_len != 0)
            send_word(plist_pkg::OP_DELETE, legal_pos(), $urandom);
        send_word(plist_pkg::OP_READ, 8'd1, $urandom);
    endtask

    task automatic test_random_ops(int unsigned n);
        int unsigned                 pick;
        plist_pkg::t_op              op;
        logic [plist_pkg::POS_W-1:0] pos;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                send_word(plist_pkg::t_op'($urandom_range(0, 3)),
                          plist_pkg::POS_W'($urandom), $urandom);
            end else begin
                // keep the list mostly short so shifts stay cheap
                pick = $urandom_range(0, 99);
                if (pick < ((shadow_len < 24) ? 40 : 15))
                    op = plist_pkg::OP_APPEND;
                else if (pick < 60)
                    op = plist_pkg::OP_INSERT;
                else if (pick < ((shadow_len > 24) ? 85 : 75))
                    op = plist_pkg::OP_DELETE;
                else
                    op = plist_pkg::OP_READ;
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    pos = 8'd0;
                else if (pick < 8)
                    pos = plist_pkg::POS_W'(shadow_len + 1);
                else
                    pos = legal_pos();
                send_word(op, pos, $urandom);
            end
        end
    endtask

    task automatic test_receiver_stall();
        hold_asked++;
        repeat (30)
            send_word(plist_pkg::t_op'($urandom_range(0, 3)), legal_pos(), $urandom);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 22;
        recv_idle_pct = 68;
        test_directed();
        test_random_ops(150);
        wait_drained();

        send_idle_pct = 68;
        recv_idle_pct = 22;
        test_fill_and_empty();
        test_random_ops(150);
        test_receiver_stall();
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_ops(150);
        test_receiver_stall();
        wait_drained();

        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
